FILE: design/index_to_key_enumerator_top_macros.svh
// Assertion macros shared by the index-to-key enumerator modules
`ifndef INDEX_TO_KEY_ENUMERATOR_TOP_MACROS_SVH
`define INDEX_TO_KEY_ENUMERATOR_TOP_MACROS_SVH

// Check on every clock edge outside reset
`define ITKE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check on every clock edge, reset included
`define ITKE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

FILE: design/itke_pkg.sv
// Shared types, constants and functions of the index-to-key enumerator
`timescale 1ns / 1ps

package itke_pkg;

  localparam int MAX_KEY_LENGTH_DEF = 16;

  localparam int IDX_W      = 64;
  localparam int LEN_CFG_W  = 5;
  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 8;
  localparam int POS_W      = 4;
  localparam int TDATA_IN_W  = 64;
  localparam int TDATA_OUT_W = 16;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [LEN_CFG_W-1:0] MIN_LENGTH_RST    = 5'd1;
  localparam logic [LEN_CFG_W-1:0] MAX_LENGTH_RST    = 5'd8;
  localparam logic [RADIX_W-1:0]   ALPHABET_SIZE_RST = 6'd36;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_DIGIT_BASE  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LETTER_BASE = 8'h57;
  localparam logic [RADIX_W-1:0] NUM_DECIMAL     = 6'd10;

  localparam int DIV_BITS   = 4;
  localparam int DIV_STEPS  = IDX_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    REG_MIN_LENGTH    = 2'd0,
    REG_MAX_LENGTH    = 2'd1,
    REG_ALPHABET_SIZE = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [LEN_CFG_W-1:0] min_length;
    logic [LEN_CFG_W-1:0] max_length;
    logic [RADIX_W-1:0]   alphabet_size;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic sub;
    logic div_start;
    logic div_step;
    logic out_digit;
    logic out_oor;
    logic pos_inc;
  } cmd_t;

  typedef struct packed {
    logic lmin_gt_lmax;
    logic pow_zero;
    logic found;
    logic len_over;
    logic div_done;
    logic out_free;
    logic digit_last;
  } status_t;

  typedef struct packed {
    logic [IDX_W-1:0]   q;
    logic [RADIX_W-1:0] r;
  } div_t;

  function automatic div_t div_step(input logic [IDX_W-1:0] q, input logic [RADIX_W-1:0] r,
                                    input logic [RADIX_W-1:0] d);
    div_t               res;
    logic [RADIX_W:0]   part;
    logic [IDX_W-1:0]   qq;
    logic [RADIX_W-1:0] rr;
    qq = q;
    rr = r;
    for (int j = 0; j < DIV_BITS; j++) begin
      part = {rr, qq[IDX_W-1]};
      qq   = {qq[IDX_W-2:0], 1'b0};
      if (part >= {1'b0, d}) begin
        part  = part - {1'b0, d};
        qq[0] = 1'b1;
      end
      rr = part[RADIX_W-1:0];
    end
    res.q = qq;
    res.r = rr;
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] alpha_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < NUM_DECIMAL) begin
      c = CHAR_DIGIT_BASE + CHAR_W'(d);
    end else begin
      c = CHAR_LETTER_BASE + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

FILE: design/itke_cfg.sv
// Configuration register file with APB-style access
`timescale 1ns / 1ps

module itke_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [itke_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [itke_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [itke_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output itke_pkg::cfg_t                    cfg_o
);

  logic [itke_pkg::LEN_CFG_W-1:0] min_length_q;
  logic [itke_pkg::LEN_CFG_W-1:0] max_length_q;
  logic [itke_pkg::RADIX_W-1:0]   alphabet_size_q;
  logic                           wr_en;
  logic [1:0]                     reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_length_q    <= itke_pkg::MIN_LENGTH_RST;
      max_length_q    <= itke_pkg::MAX_LENGTH_RST;
      alphabet_size_q <= itke_pkg::ALPHABET_SIZE_RST;
    end else if (wr_en) begin
      case (reg_sel)
        itke_pkg::REG_MIN_LENGTH: begin
          min_length_q <= pwdata[itke_pkg::LEN_CFG_W-1:0];
        end
        itke_pkg::REG_MAX_LENGTH: begin
          max_length_q <= pwdata[itke_pkg::LEN_CFG_W-1:0];
        end
        itke_pkg::REG_ALPHABET_SIZE: begin
          alphabet_size_q <= pwdata[itke_pkg::RADIX_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      itke_pkg::REG_MIN_LENGTH:    prdata = itke_pkg::APB_DATA_W'(min_length_q);
      itke_pkg::REG_MAX_LENGTH:    prdata = itke_pkg::APB_DATA_W'(max_length_q);
      itke_pkg::REG_ALPHABET_SIZE: prdata = itke_pkg::APB_DATA_W'(alphabet_size_q);
      default:                     prdata = '0;
    endcase
  end

  assign cfg_o.min_length    = min_length_q;
  assign cfg_o.max_length    = max_length_q;
  assign cfg_o.alphabet_size = alphabet_size_q;

endmodule

FILE: design/itke_ctrl.sv
// Sequencer for length search and digit extraction
`timescale 1ns / 1ps
`include "index_to_key_enumerator_top_macros.svh"

module itke_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  itke_pkg::status_t status_i,
  output itke_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POW,
    ST_SRCH,
    ST_SMUL,
    ST_DIV,
    ST_EMIT,
    ST_OOR
  } state_e;

  state_e state_q;
  state_e state_d;

  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.lmin_gt_lmax ? ST_OOR : ST_POW;
        end
      end
      ST_POW: begin
        if (status_i.pow_zero) begin
          state_d = ST_SRCH;
        end else begin
          cmd_o.mul = 1'b1;
        end
      end
      ST_SRCH: begin
        if (status_i.found) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else if (status_i.len_over) begin
          state_d = ST_OOR;
        end else begin
          cmd_o.sub = 1'b1;
          state_d   = ST_SMUL;
        end
      end
      ST_SMUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SRCH;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_digit = 1'b1;
          if (status_i.digit_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.pos_inc   = 1'b1;
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end
        end
      end
      ST_OOR: begin
        if (status_i.out_free) begin
          cmd_o.out_oor = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ITKE_ASSERT(a_out_slot_free, (cmd_o.out_digit || cmd_o.out_oor) |-> status_i.out_free, "result loaded over a pending transaction")
  `ITKE_ASSERT(a_one_out_cmd, $onehot0({cmd_o.out_digit, cmd_o.out_oor, cmd_o.load}), "conflicting commands")
  `ITKE_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !(cmd_o.out_digit || cmd_o.out_oor), "result during reset")

endmodule

FILE: design/itke_dp.sv
// Datapath: saturating key count, length search, radix divider and result register
`timescale 1ns / 1ps
`include "index_to_key_enumerator_top_macros.svh"

module itke_dp #(
  parameter int MaxKeyLength = itke_pkg::MAX_KEY_LENGTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  itke_pkg::cfg_t                     cfg_i,
  input  itke_pkg::cmd_t                     cmd_i,
  output itke_pkg::status_t                  status_o,
  input  logic [itke_pkg::TDATA_IN_W-1:0]    s_tdata_i,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  output logic [itke_pkg::TDATA_OUT_W-1:0]   m_tdata_o,
  output logic                               m_tlast_o,
  output logic                               m_tuser_o
);

  localparam int LenW  = $clog2(MaxKeyLength + 2);
  localparam int CmpW  = (LenW > itke_pkg::LEN_CFG_W) ? LenW : itke_pkg::LEN_CFG_W;
  localparam int IdxW  = itke_pkg::IDX_W;
  localparam int RadW  = itke_pkg::RADIX_W;
  localparam int ProdW = IdxW + RadW;

  logic [CmpW-1:0]  lim;
  logic [CmpW-1:0]  min_ext;
  logic [CmpW-1:0]  max_ext;
  logic [LenW-1:0]  lmin_eff;
  logic [LenW-1:0]  lmax_eff;
  logic [RadW-1:0]  radix_eff;

  logic [IdxW-1:0]  idx_q;
  logic [IdxW-1:0]  count_q;
  logic             sat_q;
  logic [LenW-1:0]  len_q;
  logic [LenW-1:0]  pow_q;
  logic [LenW-1:0]  pos_q;
  logic [RadW-1:0]  rem_q;
  logic [itke_pkg::DIV_CNT_W-1:0] div_cnt_q;

  logic             m_tvalid_q;
  logic [itke_pkg::CHAR_W-1:0] m_char_q;
  logic [itke_pkg::POS_W-1:0]  m_pos_q;
  logic             m_tlast_q;
  logic             m_tuser_q;

  logic [IdxW:0]    diff;
  logic [ProdW-1:0] prod;
  logic             prod_sat;
  itke_pkg::div_t   div_res;
  logic             digit_last;
  logic             out_load;

  assign lim = CmpW'(MaxKeyLength);

  always_comb begin
    min_ext = CmpW'(cfg_i.min_length);
    max_ext = CmpW'(cfg_i.max_length);
    if (min_ext == '0) begin
      min_ext = CmpW'(1);
    end
    if (min_ext > lim) begin
      min_ext = lim;
    end
    if (max_ext > lim) begin
      max_ext = lim;
    end
    radix_eff = cfg_i.alphabet_size;
    if (radix_eff < itke_pkg::RADIX_MIN) begin
      radix_eff = itke_pkg::RADIX_MIN;
    end
    if (radix_eff > itke_pkg::RADIX_MAX) begin
      radix_eff = itke_pkg::RADIX_MAX;
    end
  end

  assign lmin_eff = LenW'(min_ext);
  assign lmax_eff = LenW'(max_ext);

  assign diff     = {1'b0, idx_q} - {1'b0, count_q};
  assign prod     = ProdW'(count_q) * ProdW'(radix_eff);
  assign prod_sat = |prod[ProdW-1:IdxW];
  assign div_res  = itke_pkg::div_step(idx_q, rem_q, radix_eff);
  assign digit_last = (pos_q == len_q - LenW'(1));
  assign out_load   = cmd_i.out_digit | cmd_i.out_oor;

  assign status_o.lmin_gt_lmax = (min_ext > max_ext);
  assign status_o.pow_zero     = (pow_q == '0);
  assign status_o.found        = sat_q | diff[IdxW];
  assign status_o.len_over     = (len_q >= lmax_eff);
  assign status_o.div_done     = (div_cnt_q == itke_pkg::DIV_CNT_W'(itke_pkg::DIV_STEPS - 1));
  assign status_o.out_free     = ~m_tvalid_q | m_tready_i;
  assign status_o.digit_last   = digit_last;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q   <= s_tdata_i;
      count_q <= IdxW'(1);
      sat_q   <= 1'b0;
      len_q   <= lmin_eff;
      pow_q   <= lmin_eff;
      pos_q   <= '0;
    end else begin
      if (cmd_i.mul) begin
        count_q <= prod_sat ? '1 : prod[IdxW-1:0];
        sat_q   <= sat_q | prod_sat;
        pow_q   <= pow_q - LenW'(1);
      end
      if (cmd_i.sub) begin
        idx_q <= diff[IdxW-1:0];
        len_q <= len_q + LenW'(1);
      end
      if (cmd_i.div_step) begin
        idx_q     <= div_res.q;
        rem_q     <= div_res.r;
        div_cnt_q <= div_cnt_q + itke_pkg::DIV_CNT_W'(1);
      end
      if (cmd_i.div_start) begin
        rem_q     <= '0;
        div_cnt_q <= '0;
      end
      if (cmd_i.pos_inc) begin
        pos_q <= pos_q + LenW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (out_load) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_digit) begin
      m_char_q  <= itke_pkg::alpha_char(rem_q);
      m_pos_q   <= itke_pkg::POS_W'(pos_q);
      m_tlast_q <= digit_last;
      m_tuser_q <= 1'b0;
    end else if (cmd_i.out_oor) begin
      m_char_q  <= '0;
      m_pos_q   <= '0;
      m_tlast_q <= 1'b1;
      m_tuser_q <= 1'b1;
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = {{(itke_pkg::TDATA_OUT_W - itke_pkg::CHAR_W - itke_pkg::POS_W){1'b0}},
                       m_pos_q, m_char_q};
  assign m_tlast_o  = m_tlast_q;
  assign m_tuser_o  = m_tuser_q;

  `ITKE_ASSERT(a_oor_shape, (m_tvalid_q && m_tuser_q) |-> (m_tlast_q && m_char_q == '0 && m_pos_q == '0), "malformed out-of-range result")
  `ITKE_ASSERT(a_oor_loaded, cmd_i.out_oor |=> (m_tvalid_q && m_tuser_q), "out-of-range result lost")
  `ITKE_ASSERT(a_digit_char, (m_tvalid_q && !m_tuser_q) |-> (m_char_q != '0), "key character is zero")

endmodule

FILE: design/index_to_key_enumerator_top.sv
// Each key character comes from the 4-bit-per-cycle radix divider, then is emitted.
// Out-of-range indexes finish after the length search with a single result; with Lmin > Lmax
// that result follows the index load directly. A new index is accepted only after the previous
// key's last result is loaded, and output stalls delay it.
// Reset: asynchronous active low; clears control state and loads register defaults.
`timescale 1ns / 1ps

module index_to_key_enumerator_top #(
  parameter int MaxKeyLength = itke_pkg::MAX_KEY_LENGTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [63:0] key_index
  input  logic [itke_pkg::TDATA_IN_W-1:0]   s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [7:0] character, [11:8] position, [15:12] zero
  output logic [itke_pkg::TDATA_OUT_W-1:0]  m_axis_tdata_o,
  output logic                              m_axis_tlast_o,
  // [0] out_of_range
  output logic                              m_axis_tuser_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [itke_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [itke_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [itke_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  itke_pkg::cfg_t    cfg;
  itke_pkg::cmd_t    cmd;
  itke_pkg::status_t status;

  itke_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  itke_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  itke_dp #(
    .MaxKeyLength (MaxKeyLength)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .status_o   (status),
    .s_tdata_i  (s_axis_tdata_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tlast_o  (m_axis_tlast_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

endmodule

FILE: tb/sv/index_to_key_enumerator_top_tb.sv
// Self-checking testbench for the index-to-key enumerator: key streams, register writes, stalls
`timescale 1ns / 1ps

module index_to_key_enumerator_top_tb;
  import itke_pkg::*;

  localparam int   HOLD_CYCLES    = 200;
  localparam int   WATCHDOG_LIMIT = 4000;
  localparam int   DRAIN_CYCLES   = 400;
  localparam int   RANDOM_PHASES  = 11;
  localparam int   KEYS_PER_PHASE = 30;
  localparam int   NUM_DIRECTED   = 23;
  localparam logic [63:0] ALL_ONES = '1;
  localparam string KEY_ALPHABET = "0123456789abcdefghijklmnopqrstuvwxyz";

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  pos;
    logic              last;
    logic              oor;
  } key_char_t;

  localparam key_char_t OOR_RESULT = '{ch: '0, pos: '0, last: 1'b1, oor: 1'b1};

  typedef struct {
    logic [LEN_CFG_W-1:0] min_len;
    logic [LEN_CFG_W-1:0] max_len;
    logic [RADIX_W-1:0]   radix;
    logic [IDX_W-1:0]     key_index;
    bit                   typed;
    string                key;
  } key_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   m_axis_tuser;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  cfg_t      cfg_shadow = '{min_length: MIN_LENGTH_RST, max_length: MAX_LENGTH_RST,
                            alphabet_size: ALPHABET_SIZE_RST};
  key_char_t key_chars_q[$];
  int        mismatches = 0;
  int        keys_sent = 0;
  int        chars_checked = 0;
  int        settings_used = 1;
  int        idle_cycles = 0;
  bit        idle_on = 1'b1;
  bit        hold_request = 1'b0;

  key_row_t directed_rows [NUM_DIRECTED] = '{
    '{5'd1, 5'd8, 6'd36, 64'd0, 1'b1, "0"},
    '{5'd1, 5'd8, 6'd36, 64'd35, 1'b1, "z"},
    '{5'd1, 5'd8, 6'd36, 64'd36, 1'b1, "00"},
    '{5'd1, 5'd8, 6'd36, 64'd1331, 1'b1, "zz"},
    '{5'd1, 5'd8, 6'd36, 64'd2901713047667, 1'b1, "zzzzzzzz"},
    '{5'd1, 5'd8, 6'd36, 64'd2901713047668, 1'b1, ""},
    '{5'd1, 5'd8, 6'd36, ALL_ONES, 1'b1, ""},
    '{5'd1, 5'd16, 6'd2, 64'd0, 1'b1, "0"},
    '{5'd1, 5'd16, 6'd2, 64'd1, 1'b1, "1"},
    '{5'd1, 5'd16, 6'd2, 64'd2, 1'b1, "00"},
    '{5'd1, 5'd16, 6'd2, 64'd131069, 1'b1, "1111111111111111"},
    '{5'd1, 5'd16, 6'd2, 64'd131070, 1'b1, ""},
    '{5'd0, 5'd0, 6'd10, 64'd5, 1'b1, ""},
    '{5'd0, 5'd3, 6'd10, 64'd5, 1'b1, "5"},
    '{5'd16, 5'd16, 6'd36, 64'd0, 1'b1, "0000000000000000"},
    '{5'd16, 5'd16, 6'd36, ALL_ONES, 1'b0, ""},
    '{5'd31, 5'd31, 6'd63, 64'h0123_4567_89ab_cdef, 1'b0, ""},
    '{5'd17, 5'd31, 6'd1, 64'd65535, 1'b1, "1111111111111111"},
    '{5'd17, 5'd31, 6'd1, 64'd65536, 1'b1, ""},
    '{5'd5, 5'd3, 6'd36, 64'd0, 1'b1, ""},
    '{5'd1, 5'd16, 6'd36, ALL_ONES, 1'b0, ""},
    '{5'd1, 5'd4, 6'd0, 64'd3, 1'b1, "01"},
    '{5'd2, 5'd2, 6'd37, 64'd1295, 1'b1, "zz"}
  };

  index_to_key_enumerator_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),    // [63:0] key_index
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),    // [7:0] character, [11:8] position, [15:12] zero
    .m_axis_tlast_o  (m_axis_tlast),
    .m_axis_tuser_o  (m_axis_tuser),    // [0] out_of_range
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch: %s", msg);
    end
  endtask

  function automatic logic [63:0] scale_count(input logic [63:0] count, input int radix,
                                              inout bit sat);
    if (count > ALL_ONES / 64'(radix)) begin
      sat = 1'b1;
      return ALL_ONES;
    end
    return count * 64'(radix);
  endfunction

  function automatic void effective_cfg(output int lmin, output int lmax, output int radix);
    lmin  = int'(cfg_shadow.min_length);
    lmax  = int'(cfg_shadow.max_length);
    radix = int'(cfg_shadow.alphabet_size);
    if (lmin < 1) lmin = 1;
    if (lmin > MAX_KEY_LENGTH_DEF) lmin = MAX_KEY_LENGTH_DEF;
    if (lmax > MAX_KEY_LENGTH_DEF) lmax = MAX_KEY_LENGTH_DEF;
    if (radix < int'(RADIX_MIN)) radix = int'(RADIX_MIN);
    if (radix > int'(RADIX_MAX)) radix = int'(RADIX_MAX);
  endfunction

  // Length search, then base-radix digits least significant first
  function automatic void predict_key(input logic [63:0] key_index);
    int          lmin;
    int          lmax;
    int          radix;
    int          len;
    int          digit;
    logic [63:0] rem;
    logic [63:0] count;
    bit          sat;
    key_char_t   kc;
    effective_cfg(lmin, lmax, radix);
    if (lmin > lmax) begin
      key_chars_q.push_back(OOR_RESULT);
      return;
    end
    rem   = key_index;
    count = 64'd1;
    sat   = 1'b0;
    for (int i = 0; i < lmin; i++) count = scale_count(count, radix, sat);
    len = lmin;
    while (!sat && rem >= count) begin
      rem -= count;
      len++;
      if (len > lmax) begin
        key_chars_q.push_back(OOR_RESULT);
        return;
      end
      count = scale_count(count, radix, sat);
    end
    for (int i = 0; i < len; i++) begin
      digit   = int'(rem % 64'(radix));
      rem     = rem / 64'(radix);
      kc.ch   = KEY_ALPHABET[digit];
      kc.pos  = POS_W'(i);
      kc.last = (i == len - 1);
      kc.oor  = 1'b0;
      key_chars_q.push_back(kc);
    end
  endfunction

  // Offer one key index; queue its characters once the transaction is accepted
  task automatic offer_key(input logic [63:0] key_index, input bit typed, input string key);
    key_char_t kc;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key_index;
    do @(posedge clk_i); while (!s_axis_tready);
    keys_sent++;
    if (!typed) begin
      predict_key(key_index);
    end else if (key.len() == 0) begin
      key_chars_q.push_back(OOR_RESULT);
    end else begin
      for (int i = 0; i < key.len(); i++) begin
        kc.ch   = key[key.len() - 1 - i];
        kc.pos  = POS_W'(i);
        kc.last = (i == key.len() - 1);
        kc.oor  = 1'b0;
        key_chars_q.push_back(kc);
      end
    end
  endtask

  task automatic drain_keys();
    s_axis_tvalid <= 1'b0;
    while (key_chars_q.size() != 0) @(posedge clk_i);
  endtask

  // Write one register, then read it back; psel is held by the caller
  task automatic access_reg(input reg_idx_e r, input logic [31:0] value,
                            input logic [31:0] mask);
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {r, 2'b00};
    pwdata  <= value | ($urandom & ~mask);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== (value & mask)) begin
      note_mismatch($sformatf("register %s read %h, expected %h", r.name(), prdata,
                              value & mask));
    end
  endtask

  task automatic program_keyspace(input logic [LEN_CFG_W-1:0] min_len,
                                  input logic [LEN_CFG_W-1:0] max_len,
                                  input logic [RADIX_W-1:0] radix);
    psel <= 1'b1;
    access_reg(REG_MIN_LENGTH, 32'(min_len), 32'h1f);
    access_reg(REG_MAX_LENGTH, 32'(max_len), 32'h1f);
    access_reg(REG_ALPHABET_SIZE, 32'(radix), 32'h3f);
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg_shadow.min_length    = min_len;
    cfg_shadow.max_length    = max_len;
    cfg_shadow.alphabet_size = radix;
    settings_used++;
  endtask

  // Mostly well-formed indexes aimed at one key length, boundaries included
  function automatic logic [63:0] pick_key_index();
    int          lmin;
    int          lmax;
    int          radix;
    int          target;
    logic [63:0] base;
    logic [63:0] count;
    bit          sat;
    effective_cfg(lmin, lmax, radix);
    if (lmin > lmax || $urandom_range(0, 4) == 0) return {$urandom, $urandom};
    target = $urandom_range(lmin, lmax);
    base   = '0;
    count  = 64'd1;
    sat    = 1'b0;
    for (int l = 0; l < lmin; l++) count = scale_count(count, radix, sat);
    for (int l = lmin; l < target && !sat; l++) begin
      base += count;
      count = scale_count(count, radix, sat);
    end
    case ($urandom_range(0, 5))
      0: return base;
      1: return base + count - 64'd1;
      2: return base + count;
      default: return base + ({$urandom, $urandom} % count);
    endcase
  endfunction

  initial begin
    logic [LEN_CFG_W-1:0] min_len;
    logic [LEN_CFG_W-1:0] max_len;
    logic [RADIX_W-1:0]   radix;
    wait (rst_ni);
    @(posedge clk_i);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].min_len != cfg_shadow.min_length ||
          directed_rows[i].max_len != cfg_shadow.max_length ||
          directed_rows[i].radix != cfg_shadow.alphabet_size) begin
        drain_keys();
        program_keyspace(directed_rows[i].min_len, directed_rows[i].max_len,
                         directed_rows[i].radix);
      end
      offer_key(directed_rows[i].key_index, directed_rows[i].typed, directed_rows[i].key);
    end
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_keys();
      if ($urandom_range(0, 3) == 0) begin
        min_len = LEN_CFG_W'($urandom_range(0, 31));
        max_len = LEN_CFG_W'($urandom_range(0, 31));
        radix   = RADIX_W'($urandom_range(0, 63));
      end else begin
        min_len = LEN_CFG_W'($urandom_range(1, 4));
        max_len = LEN_CFG_W'($urandom_range(32'(min_len), 32'(min_len) + 32'd4));
        radix   = RADIX_W'($urandom_range(2, 36));
      end
      program_keyspace(min_len, max_len, radix);
      if (p == 2) hold_request = 1'b1;
      if (p == RANDOM_PHASES - 1) idle_on = 1'b0;
      for (int k = 0; k < KEYS_PER_PHASE; k++) begin
        offer_key(pick_key_index(), 1'b0, "");
      end
    end
    drain_keys();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d key indexes, %0d key characters checked, %0d register settings",
             keys_sent, chars_checked, settings_used);
    $display("including clamped lengths and radix, saturated counts and out-of-range indexes");
    if (mismatches == 0) begin
      $display("index_to_key_enumerator_top regression: pass");
    end else begin
      $display("index_to_key_enumerator_top regression: fail");
    end
    $finish;
  end

  initial begin
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    key_char_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (key_chars_q.size() == 0) begin
        note_mismatch($sformatf("unexpected character %h pos %0d last %b oor %b",
                                m_axis_tdata[7:0], m_axis_tdata[11:8], m_axis_tlast,
                                m_axis_tuser));
      end else begin
        want = key_chars_q.pop_front();
        chars_checked++;
        if (m_axis_tdata[7:0] !== want.ch || m_axis_tdata[11:8] !== want.pos ||
            m_axis_tlast !== want.last || m_axis_tuser !== want.oor) begin
          note_mismatch($sformatf(
            "expected char %h pos %0d last %b oor %b, got char %h pos %0d last %b oor %b",
            want.ch, want.pos, want.last, want.oor, m_axis_tdata[7:0], m_axis_tdata[11:8],
            m_axis_tlast, m_axis_tuser));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("index_to_key_enumerator_top regression: fail");
      $finish;
    end
  end

endmodule
